>>> src/mdcs_pkg.sv
`timescale 1ns / 1ps
// Package for the motor drip/clean sequencer: payload structs, command codes,
// controller states, command/status structs and the fixed profile tables.
package mdcs_pkg;

    localparam int DutyMax = 1023;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SPEED    = 3'd1,
        CMD_TIMED    = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_CLN_FAST = 3'd4,
        CMD_CLN_SLOW = 3'd5,
        CMD_CLN_MAN  = 3'd6,
        CMD_PURGE    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        REG_PULSE_DUTY = 2'd0,
        REG_PULSE_MS   = 2'd1,
        REG_PURGE_MS   = 2'd2,
        REG_KICK_MS    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  speed;
        logic [31:0] duration_ms;
    } in_item_t;

    typedef struct packed {
        logic [9:0] duty;
        logic       beep;
        logic       drip_active;
        logic       clean_active;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic step1;
        logic step2;
        logic step3;
    } ctl_cmd_t;

    typedef logic [127:0][9:0]  duty_tbl_t;
    typedef logic [127:0][13:0] period_tbl_t;

    // phase 1: kick+drip, phase 2: speed, drip start and clean, phase 3: timeout and stop

    function automatic logic [15:0] prof_on(input logic [1:0] m);
        case (m)
            2'd0:    prof_on = 16'd5000;
            2'd1:    prof_on = 16'd20000;
            default: prof_on = 16'd2000;
        endcase
    endfunction

    function automatic logic [15:0] prof_off(input logic [1:0] m);
        case (m)
            2'd0:    prof_off = 16'd1000;
            2'd1:    prof_off = 16'd2000;
            default: prof_off = 16'd500;
        endcase
    endfunction

    function automatic logic [6:0] prof_speed(input logic [1:0] m);
        case (m)
            2'd1:    prof_speed = 7'd60;
            default: prof_speed = 7'd100;
        endcase
    endfunction

    function automatic logic [3:0] prof_cycles(input logic [1:0] m);
        case (m)
            2'd2:    prof_cycles = 4'd15;
            default: prof_cycles = 4'd10;
        endcase
    endfunction

    // duty curve for 1..100, computed at elaboration
    function automatic logic [9:0] curve_duty(input logic [6:0] p);
        logic [31:0] v;
        v = 32'(p) * 32'(p) * 32'd8 + 32'd20000;
        if (p == 7'd0)
            curve_duty = '0;
        else
            curve_duty = 10'((64'(v) * 64'(DutyMax)) / 64'd100000);
    endfunction

    function automatic logic [9:0] pct_duty(input logic [6:0] p);
        pct_duty = 10'((32'(p) * 32'(DutyMax)) / 32'd100);
    endfunction

    // burst period for speed 1..100
    function automatic logic [13:0] drip_period_of(input logic [6:0] p);
        logic [15:0] mapped;
        logic [15:0] per;
        mapped = 16'((32'(p) * 32'd45 + 32'd99) / 32'd100);
        if (mapped == 16'd0)
            per = 16'd50;
        else
            per = 16'(32'd10000 / 32'(mapped));
        if (per < 16'd50)
            per = 16'd50;
        drip_period_of = per[13:0];
    endfunction

    function automatic duty_tbl_t build_curve_tbl();
        duty_tbl_t tbl;
        for (int p = 0; p < 128; p++)
            tbl[p] = curve_duty(7'(p));
        return tbl;
    endfunction

    function automatic duty_tbl_t build_pct_tbl();
        duty_tbl_t tbl;
        for (int p = 0; p < 128; p++)
            tbl[p] = pct_duty(7'(p));
        return tbl;
    endfunction

    function automatic period_tbl_t build_period_tbl();
        period_tbl_t tbl;
        for (int p = 0; p < 128; p++)
            tbl[p] = drip_period_of(7'(p));
        return tbl;
    endfunction

    localparam duty_tbl_t   CurveTbl  = build_curve_tbl();
    localparam duty_tbl_t   PctTbl    = build_pct_tbl();
    localparam period_tbl_t PeriodTbl = build_period_tbl();

endpackage

>>> src/mdcs_ctrl.sv
`timescale 1ns / 1ps
// Controller for the sequencer: sequences the per-item phases and the
// result handshake. Depends on mdcs_pkg.
module mdcs_ctrl
    import mdcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_stall,
    output logic     in_stall,
    output logic     out_valid,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_S1;
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_S3;
            ST_S3:   state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = in_valid ? ST_S1 : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_S1:   cmd.step1 = 1'b1;
            ST_S2:   cmd.step2 = 1'b1;
            ST_S3:   cmd.step3 = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_stall  = out_stall;
                cmd.start = in_valid && !out_stall;
            end
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && (cmd.step1 || cmd.step2 || cmd.step3)))
        else $error("result shown mid-item");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step1 |=> cmd.step2)
        else $error("phase order broken");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

endmodule

>>> src/mdcs_dp.sv
`timescale 1ns / 1ps
// Datapath for the sequencer: motor, drip, clean and timeout state, the
// configuration registers and the result register. Depends on mdcs_pkg.
module mdcs_dp
    import mdcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_cmd_t   cmd,
    input  in_item_t   item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_idx,
    input  logic [15:0] cfg_wdata,
    output out_item_t  res
);

    logic [6:0]  pdut_reg;
    logic [9:0]  pms_reg, kms_reg;
    logic [15:0] purge_reg;

    in_item_t    it_reg;
    logic [9:0]  duty_reg, duty_next, tgt_reg, tgt_next, kick_reg, kick_next;
    logic        run_reg, run_next, don_reg, don_next, dph_reg, dph_next;
    logic [13:0] dper_reg, dper_next, dcnt_reg, dcnt_next;
    logic [31:0] tmo_reg, tmo_next;
    logic [1:0]  cm_reg, cm_next;
    logic [3:0]  cyc_reg, cyc_next;
    logic        cph_reg, cph_next, beep_reg, beep_next;
    logic [14:0] ccnt_reg, ccnt_next;

    logic [6:0] spd, pd;
    logic [9:0] pms1, kms1;
    logic [1:0] m;
    logic [9:0] kick_duty;

    assign kick_duty = 10'((32'(DutyMax) * 32'd7) / 32'd10);
    assign spd  = (it_reg.speed > 8'd100) ? 7'd100 : it_reg.speed[6:0];
    assign pd   = (pdut_reg > 7'd100) ? 7'd100 : pdut_reg;
    assign pms1 = (pms_reg == '0) ? 10'd1 : pms_reg;
    assign kms1 = (kms_reg == '0) ? 10'd1 : kms_reg;
    assign m    = it_reg.command[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdut_reg  <= 7'd70;
            pms_reg   <= 10'd10;
            purge_reg <= 16'd20000;
            kms_reg   <= 10'd100;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_PULSE_DUTY: pdut_reg  <= cfg_wdata[6:0];
                REG_PULSE_MS:   pms_reg   <= cfg_wdata[9:0];
                REG_PURGE_MS:   purge_reg <= cfg_wdata;
                REG_KICK_MS:    kms_reg   <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            it_reg <= item;
    end

    always_comb
    begin
        logic [9:0] t;
        logic       sp_en;
        logic [6:0] sp_v;
        duty_next = duty_reg; tgt_next = tgt_reg; kick_next = kick_reg;
        run_next = run_reg; don_next = don_reg; dph_next = dph_reg;
        dper_next = dper_reg; dcnt_next = dcnt_reg; tmo_next = tmo_reg;
        cm_next = cm_reg; cyc_next = cyc_reg; cph_next = cph_reg;
        ccnt_next = ccnt_reg; beep_next = beep_reg;
        sp_en = 1'b0; sp_v = '0;
        t = '0;
        if (cmd.start)
            beep_next = 1'b0;
        if (cmd.step1)
        begin
            if (cmd_t'(it_reg.command) == CMD_TICK)
            begin
                if (kick_reg != '0)
                begin
                    kick_next = kick_reg - 10'd1;
                    if (kick_reg == 10'd1 && run_reg)
                        duty_next = tgt_reg;
                end
                if (don_reg && dcnt_reg != '0 && dcnt_reg == 14'd1)
                begin
                    if (dph_reg)
                    begin
                        duty_next = '0;
                        dph_next  = 1'b0;
                        dcnt_next = (dper_reg > 14'(pms1)) ? dper_reg - 14'(pms1) : 14'd10;
                    end
                    else
                    begin
                        duty_next = PctTbl[pd];
                        dph_next  = 1'b1;
                        dcnt_next = 14'(pms1);
                    end
                end
                else if (don_reg && dcnt_reg != '0)
                    dcnt_next = dcnt_reg - 14'd1;
            end
            else if (cmd_t'(it_reg.command) != CMD_STOP && don_reg)
            begin
                don_next = 1'b0; dcnt_next = '0; duty_next = '0;
            end
        end
        if (cmd.step2)
        begin
            case (cmd_t'(it_reg.command))
                CMD_TICK:
                    if (ccnt_reg != '0)
                    begin
                        ccnt_next = ccnt_reg - 15'd1;
                        if (ccnt_reg == 15'd1 && cm_reg != 2'd0)
                        begin
                            if (cph_reg)
                            begin
                                sp_en = 1'b1;
                                cph_next = 1'b0;
                                if (cyc_reg == 4'd1 || cyc_reg == 4'd0)
                                begin
                                    cyc_next = '0; cm_next = '0; beep_next = 1'b1;
                                end
                                else
                                begin
                                    cyc_next  = cyc_reg - 4'd1;
                                    ccnt_next = 15'(prof_off(cm_reg - 2'd1));
                                end
                            end
                            else
                            begin
                                sp_en = 1'b1; sp_v = prof_speed(cm_reg - 2'd1);
                                cph_next  = 1'b1;
                                ccnt_next = 15'(prof_on(cm_reg - 2'd1));
                            end
                        end
                    end
                CMD_SPEED: begin sp_en = 1'b1; sp_v = spd; end
                CMD_TIMED:
                    if (spd != '0)
                    begin
                        don_next  = 1'b1;
                        dper_next = PeriodTbl[spd];
                        dph_next  = 1'b1;
                        duty_next = PctTbl[pd];
                        dcnt_next = 14'(pms1);
                    end
                CMD_CLN_FAST, CMD_CLN_SLOW, CMD_CLN_MAN:
                begin
                    cm_next  = m + 2'd1;
                    cyc_next = prof_cycles(m);
                    cph_next = 1'b1;
                    sp_en = 1'b1; sp_v = prof_speed(m);
                    ccnt_next = 15'(prof_on(m));
                end
                CMD_PURGE: begin sp_en = 1'b1; sp_v = 7'd100; end
                default: ;
            endcase
            if (sp_en)
            begin
                if (sp_v == '0)
                begin
                    run_next = 1'b0; kick_next = '0; duty_next = '0;
                end
                else
                begin
                    t = CurveTbl[sp_v];
                    tgt_next = t;
                    if (!run_reg)
                    begin
                        run_next = 1'b1;
                        if (32'(t) < 32'(DutyMax / 2))
                        begin
                            duty_next = kick_duty;
                            kick_next = kms1;
                        end
                        else
                            duty_next = t;
                    end
                    else
                        duty_next = t;
                end
            end
        end
        if (cmd.step3)
        begin
            case (cmd_t'(it_reg.command))
                CMD_TICK:
                    if (tmo_reg != '0)
                    begin
                        tmo_next = tmo_reg - 32'd1;
                        if (tmo_reg == 32'd1)
                            beep_next = 1'b1;
                    end
                CMD_TIMED:
                    if (it_reg.duration_ms != '0)
                        tmo_next = it_reg.duration_ms;
                CMD_PURGE:
                    tmo_next = (purge_reg == '0) ? 32'd1 : 32'(purge_reg);
                default: ;
            endcase
            if ((cmd_t'(it_reg.command) == CMD_TICK && tmo_reg == 32'd1)
                || cmd_t'(it_reg.command) == CMD_STOP)
            begin
                if (don_reg)
                    duty_next = '0;
                don_next = 1'b0; dcnt_next = '0;
                tmo_next = '0; ccnt_next = '0;
                run_next = 1'b0; kick_next = '0; duty_next = '0;
                cm_next = '0; cyc_next = '0; cph_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0; tgt_reg <= '0; kick_reg <= '0; run_reg <= 1'b0;
            don_reg <= 1'b0; dph_reg <= 1'b0; dper_reg <= '0; dcnt_reg <= '0;
            tmo_reg <= '0; cm_reg <= '0; cyc_reg <= '0; cph_reg <= 1'b0;
            ccnt_reg <= '0; beep_reg <= 1'b0;
        end
        else
        begin
            duty_reg <= duty_next; tgt_reg <= tgt_next; kick_reg <= kick_next;
            run_reg <= run_next; don_reg <= don_next; dph_reg <= dph_next;
            dper_reg <= dper_next; dcnt_reg <= dcnt_next; tmo_reg <= tmo_next;
            cm_reg <= cm_next; cyc_reg <= cyc_next; cph_reg <= cph_next;
            ccnt_reg <= ccnt_next; beep_reg <= beep_next;
        end
    end

    assign res.duty         = duty_reg;
    assign res.beep         = beep_reg;
    assign res.drip_active  = don_reg;
    assign res.clean_active = (cm_reg != 2'd0);

    a_drip_period: assert property (@(posedge clk) disable iff (!rst_n)
        don_reg |-> dper_reg >= 14'd50)
        else $error("burst period below floor");
    a_clean_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cm_reg == 2'd0 |-> !cph_reg || ccnt_reg != '0 || $past(cm_reg) == 2'd0)
        else $error("clean phase left on");
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step3 && cmd_t'(it_reg.command) == CMD_STOP |=> duty_reg == '0 && !don_reg)
        else $error("stop left motor driven");

endmodule

>>> src/motor_drip_clean_sequencer_top.sv
`timescale 1ns / 1ps
// Motor drip/clean sequencer top level: command/tick in, one duty result out.
// Depends on mdcs_pkg, mdcs_ctrl and mdcs_dp.
//
// Input channel in/in_valid/in_stall carries command, speed and duration_ms.
// Each transfer yields exactly one result on out/out_valid/out_stall: the
// duty now held, a beep flag, and drip and clean activity flags.
// An item is captured, then runs three datapath phases in order
// (kickstart and drip counters, speed and clean sequence, timeout and stop),
// then the result is shown. The next item is taken in the same cycle the
// result transfers, so a new item is not taken before the last result has
// gone; this order is set by the phase sequencer in the controller.
// Reset clears all motor state and loads the register defaults (pulse duty
// 70, pulse 10 ticks, purge 20000 ticks, kickstart 100 ticks).
// While out_stall is high with a result shown, the result holds and in_stall stays high.
// Configuration: cfg_we, cfg_index and cfg_data; write only while idle.
module motor_drip_clean_sequencer_top
    import mdcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in,
    input  logic        in_valid,
    output logic        in_stall,
    output out_item_t   out,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ctl_cmd_t cmd;

    mdcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mdcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (in),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .res       (out)
    );

endmodule
